// ===== sv/fcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcmc_pkg
// Shared types, codes and constants of the FIFO cache miss counter.
// ----------------------------------------------------------------------------
package fcmc_pkg;

    localparam int unsigned NUM_CACHES_DEF  = 4;
    localparam int unsigned MAX_ENTRIES_DEF = 16;
    localparam int unsigned ADDR_BITS_DEF   = 32;
    localparam int unsigned CAP_W           = 5;
    localparam logic [4:0]  CAP_RESET       = 5'd16;
    localparam int unsigned NUM_CAP_REGS    = 4;

    localparam logic [1:0] OP_ADDR = 2'd0;
    localparam logic [1:0] OP_RANG = 2'd1;
    localparam logic [1:0] OP_STAT = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
        logic [31:0] stride;
        logic [15:0] count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  cache_index;
        logic [31:0] miss_count;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_UPD,
        ST_STAT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input item
        logic rd;        // issue entry read for current slot
        logic cmp;       // compare read data against the key
        logic upd;       // apply miss update, step address
        logic stat_emit; // drive current cache's count on the output
        logic stat_clr;  // clear that count and advance cache
    } t_cmd;

    typedef struct packed {
        logic scan_done; // reads issued for all slots of all caches
        logic upd_last;  // the update step is on the final cache
        logic rng_done;  // no addresses remaining after the current one
        logic stat_last; // the current stat cache is the final one
    } t_sts;

endpackage

// ===== sv/fcmc_ram.sv =====
// ----------------------------------------------------------------------------
// fcmc_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcmc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/fcmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcmc_ctrl
// Controller state machine of the FIFO cache miss counter.
// ----------------------------------------------------------------------------
module fcmc_ctrl
    import fcmc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_out_ready,
    input  t_sts     i_sts,
    output logic     o_ready,
    output logic     o_out_valid,
    output t_cmd     o_cmd
);
    t_state r_state, n_state;
    logic   w_acc;

    assign w_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_item.opcode)
                        OP_ADDR: n_state = ST_READ;
                        OP_RANG: n_state = (i_item.count != '0) ? ST_READ : ST_IDLE;
                        OP_STAT: n_state = ST_STAT;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP:  n_state = i_sts.scan_done ? ST_UPD : ST_CMP;
            ST_UPD: begin
                if (i_sts.upd_last) begin
                    n_state = i_sts.rng_done ? ST_IDLE : ST_READ;
                end
            end
            ST_STAT: begin
                if (i_out_ready && i_sts.stat_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = w_acc;
            end
            ST_READ: o_cmd.rd = 1'b1;
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                o_cmd.rd  = !i_sts.scan_done;
            end
            ST_UPD: o_cmd.upd = 1'b1;
            ST_STAT: begin
                o_out_valid       = 1'b1;
                o_cmd.stat_emit   = 1'b1;
                o_cmd.stat_clr    = i_out_ready;
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_out_valid)
        else $error("ready and output valid at once");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> (r_state != ST_CMP && r_state != ST_STAT))
        else $error("update not followed by update, idle or read");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_CMP))
        else $error("read not followed by compare");
endmodule

// ===== sv/fcmc_dp.sv =====
// ----------------------------------------------------------------------------
// fcmc_dp
// Datapath: capacity registers, per-cache FIFO state, miss counters, and
// the entry scan over the shared entry memory.
// ----------------------------------------------------------------------------
module fcmc_dp
    import fcmc_pkg::*;
#(
    parameter int unsigned NUM_CACHES  = NUM_CACHES_DEF,
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output t_out_item   o_item
);
    localparam int unsigned CW = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
    localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned FW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned DEPTH = NUM_CACHES * (2 ** EW);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [FW-1:0] MAXE = FW'(MAX_ENTRIES);

    logic [CAP_W-1:0]     r_cap  [NUM_CACHES];
    logic [FW-1:0]        r_fill [NUM_CACHES];
    logic [EW-1:0]        r_ptr  [NUM_CACHES];
    logic [31:0]          r_miss [NUM_CACHES];
    logic [NUM_CACHES-1:0] r_hit;
    logic [31:0]          r_addr, r_stride;
    logic [15:0]          r_cnt;
    logic [CW-1:0]        r_c, r_sc;   // scan cache, stat cache
    logic [FW-1:0]        r_s;         // scan slot
    logic [CW-1:0]        r_cc;        // cache of the data in flight
    logic [FW-1:0]        r_cs;
    logic [ADDR_BITS-1:0] w_rdata, w_key;
    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [CW-1:0]        r_wc;
    logic                 r_done, r_rdv;
    logic                 w_last_slot, w_last_cache;
    logic                 w_upd_miss;

    // Effective capacity: zero acts as one, clamp to MAX_ENTRIES.
    function automatic logic [FW-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        if (cap == '0) return FW'(1);
        if (32'(cap) > MAX_ENTRIES) return MAXE;
        return FW'(cap);
    endfunction

    function automatic logic [FW-1:0] eff_fill(input logic [FW-1:0] f,
                                                input logic [FW-1:0] c);
        return (f > c) ? c : f;
    endfunction

    assign w_key = ADDR_BITS'(r_addr);
    // Reads: cache r_c, slot r_s.
    assign w_raddr = AW'({r_c, r_s[EW-1:0]});

    // Scan walks slots of each cache up to its fill; caches with empty
    // fill are skipped with a read of slot zero that is ignored.
    always_comb begin
        w_last_slot  = (32'(r_s) + 32'd1 >= 32'(eff_fill(r_fill[r_c], eff_cap(r_cap[r_c]))));
        w_last_cache = (32'(r_c) == NUM_CACHES - 1);
    end
    assign o_sts.scan_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_rdv  <= 1'b0;
        end else begin
            if (i_cmd.load || i_cmd.upd) begin
                r_done <= 1'b0;
            end else if (i_cmd.rd && w_last_slot && w_last_cache) begin
                r_done <= 1'b1;
            end
            r_rdv <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_cc <= r_c;
            r_cs <= r_s;
        end
    end

    // One write per missing cache, sequenced through r_wc during update.
    fcmc_ram #(.WIDTH(ADDR_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_key),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_sts.upd_last  = (r_wc == CW'(NUM_CACHES - 1));
    assign o_sts.rng_done  = (r_cnt <= 16'd1);
    assign o_sts.stat_last = (32'(r_sc) == NUM_CACHES - 1);

    // The pointer always stays below the capacity, so it is the write slot.
    assign w_upd_miss = i_cmd.upd && !r_hit[r_wc];
    assign w_we    = w_upd_miss;
    assign w_waddr = AW'({r_wc, r_ptr[r_wc]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c  <= '0;
            r_s  <= '0;
            r_wc <= '0;
            r_sc <= '0;
            r_hit <= '0;
            r_cnt <= '0;
            for (int i = 0; i < NUM_CACHES; i++) begin
                r_cap[i]  <= CAP_RESET;
                r_fill[i] <= '0;
                r_ptr[i]  <= '0;
                r_miss[i] <= '0;
            end
        end else begin
            if (i_cfg_we && 32'(i_cfg_idx) < NUM_CACHES) begin
                r_cap[CW'(i_cfg_idx)]  <= i_cfg_data;
                r_fill[CW'(i_cfg_idx)] <= '0;
                r_ptr[CW'(i_cfg_idx)]  <= '0;
            end
            if (i_cmd.load) begin
                r_addr   <= i_item.address;
                r_stride <= i_item.stride;
                r_cnt    <= (i_item.opcode == OP_RANG) ? i_item.count : 16'd1;
                r_c <= '0; r_s <= '0; r_wc <= '0; r_sc <= '0;
                r_hit <= '0;
            end
            if (i_cmd.rd) begin
                if (w_last_slot) begin
                    r_s <= '0;
                    if (!w_last_cache) r_c <= r_c + CW'(1);
                end else begin
                    r_s <= r_s + FW'(1);
                end
            end
            if (i_cmd.cmp && r_rdv
                && r_cs < eff_fill(r_fill[r_cc], eff_cap(r_cap[r_cc]))
                && w_rdata == w_key) begin
                r_hit[r_cc] <= 1'b1;
            end
            if (i_cmd.upd) begin
                if (!r_hit[r_wc]) begin
                    if (r_miss[r_wc] != '1) r_miss[r_wc] <= r_miss[r_wc] + 32'd1;
                    r_ptr[r_wc] <= (FW'(r_ptr[r_wc]) + FW'(1) >= eff_cap(r_cap[r_wc]))
                                   ? '0 : r_ptr[r_wc] + EW'(1);
                    r_fill[r_wc] <= (eff_fill(r_fill[r_wc], eff_cap(r_cap[r_wc]))
                                     < eff_cap(r_cap[r_wc]))
                                    ? eff_fill(r_fill[r_wc], eff_cap(r_cap[r_wc])) + FW'(1)
                                    : eff_cap(r_cap[r_wc]);
                end
                if (r_wc == CW'(NUM_CACHES - 1)) begin
                    r_wc  <= '0;
                    r_c   <= '0;
                    r_s   <= '0;
                    r_hit <= '0;
                    r_cnt <= r_cnt - 16'd1;
                    r_addr <= r_addr + r_stride;
                end else begin
                    r_wc <= r_wc + CW'(1);
                end
            end
            if (i_cmd.stat_clr) begin
                r_miss[r_sc] <= '0;
                r_sc <= r_sc + CW'(1);
            end
        end
    end

    assign o_item.cache_index = 2'(r_sc);
    assign o_item.miss_count  = r_miss[r_sc];
    assign o_item.last        = o_sts.stat_last;
endmodule

// ===== sv/fifo_cache_miss_counter_core.sv =====
// ----------------------------------------------------------------------------
// fifo_cache_miss_counter_core
// Several FIFO-replacement fully associative caches counting misses.
// ----------------------------------------------------------------------------
// The input channel takes one item at a time: a single access, a range
// access, or a stat request. Accesses yield no results. A stat request
// yields one item per cache, the final one flagged by last, and clears the
// counts. The configuration channel is ready only while the block is idle.
// An item is accepted while the block is idle. Each address then reads
// every filled slot of every cache through the shared entry memory, one
// slot per cycle, with one read for a cache that is still empty, then
// compares the final read and updates each cache in turn. A range access
// repeats these steps for count addresses, stepping by the stride. A stat
// request emits the result of each cache in turn; a stall holds the current
// result and the input stays not ready until the final result is taken.
// Reset clears fill counts, pointers and counters and sets capacities to
// their maximum; entry memory needs no clearing since only filled slots
// are ever compared.
// ----------------------------------------------------------------------------
module fifo_cache_miss_counter_core
    import fcmc_pkg::*;
#(
    parameter int unsigned NUM_CACHES  = NUM_CACHES_DEF,
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_cfg_we;

    // Configuration is accepted only while no item is in flight.
    assign o_cfg_ready = o_ready;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    fcmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .i_out_ready(i_ready),
        .i_sts      (w_sts),
        .o_ready    (o_ready),
        .o_out_valid(o_valid),
        .o_cmd      (w_cmd)
    );

    fcmc_dp #(
        .NUM_CACHES (NUM_CACHES),
        .MAX_ENTRIES(MAX_ENTRIES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cfg_we  (w_cfg_we),
        .i_cfg_idx (i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_item    (o_item)
    );
endmodule
